FILE: rtl/sacht_pkg.sv
// Shared types and constants for the set-associative cache hit tracker.
// Holds the address split, the policy and state codes; no dependencies.

package sacht_pkg;

   // Cache geometry (powers of two; the address split is a plain bit slice)
   localparam int SETS            = 64;
   localparam int WORDS_PER_BLOCK = 4;
   localparam int ADDR_BITS       = 32;
   localparam int WAYS_DEFAULT    = 4;

   localparam int OFFSET_BITS = $clog2(WORDS_PER_BLOCK);
   localparam int SET_BITS    = $clog2(SETS);
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;

   // Result field widths
   localparam int SET_OUT_BITS = 6;
   localparam int WAY_OUT_BITS = 2;
   localparam int COUNT_BITS   = 32;
   localparam int POLICY_BITS  = 2;

   // Replacement policy codes; the unused code behaves as least recently used
   typedef enum logic [POLICY_BITS-1:0] {
      POL_LRU  = 2'd0,
      POL_MRU  = 2'd1,
      POL_FIFO = 2'd2
   } policy_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

FILE: rtl/sacht_channels.sv
// Handshake channels of the cache hit tracker: access, result and policy write.
// Depends on sacht_pkg for the field widths.

interface sacht_req_if;
   logic                             valid;
   logic                             ready;
   logic [sacht_pkg::ADDR_BITS-1:0]  address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacht_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [sacht_pkg::SET_OUT_BITS-1:0]  set_index;
   logic [sacht_pkg::WAY_OUT_BITS-1:0]  way_used;
   logic [sacht_pkg::COUNT_BITS-1:0]    hit_total;
   logic [sacht_pkg::COUNT_BITS-1:0]    access_total;

   modport source (output valid, output hit, output set_index, output way_used,
                   output hit_total, output access_total, input ready);
   modport sink   (input valid, input hit, input set_index, input way_used,
                   input hit_total, input access_total, output ready);
endinterface

interface sacht_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sacht_pkg::POLICY_BITS-1:0]  policy;

   modport source (output valid, output policy, input ready);
   modport sink   (input valid, input policy, output ready);
endinterface

FILE: rtl/set_assoc_cache_hit_tracker_unit.sv
// Top level of the set-associative cache hit tracker (tag-only cache model).
// Depends on sacht_pkg and the channel interfaces in sacht_channels.sv.

// Each accepted item is one word address; the block looks it up in a tag-only
// cache of SETS sets and WAYS ways and returns one result item: hit or miss,
// the set, the way that hit or was filled, and saturating hit and access
// counts that include this access. Misses fill the lowest invalid way, or
// else replace a victim chosen by the policy register (0 least recently used,
// 1 most recently used, 2 first in first out, 3 as 0). The set's row is read
// out of the tag memory and the status memory (valid bits and age ranks) into
// registers; the lookup then compares, updates and writes it back, waiting
// while the output register is full. The single read-modify-write port pair
// means no new item is taken until the last is written back. A result waits
// in an output register while the next item is taken. After reset the
// block sweeps the status memory, one set a cycle, over all SETS sets (64 by
// default) before taking the first item; policy writes are taken at any time.

module set_assoc_cache_hit_tracker_unit #(
   parameter int WAYS = sacht_pkg::WAYS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sacht_req_if.sink    req_bus,
   sacht_rsp_if.source  rsp_bus,
   sacht_csr_if.sink    csr_bus
);

   // Way index and age rank share a width; a one-way cache still gets one bit
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int META_W = WAYS * (1 + RANK_W);
   localparam int TROW_W = WAYS * sacht_pkg::TAG_BITS;
   localparam logic [RANK_W-1:0] OLDEST = RANK_W'(WAYS - 1);

   // ------------------------------------------------------------------
   // Storage: one row per set in each memory
   // Status row: valid bits in the low WAYS bits, ranks above them.
   // ------------------------------------------------------------------
   logic [TROW_W-1:0] tag_mem  [sacht_pkg::SETS];
   logic [META_W-1:0] meta_mem [sacht_pkg::SETS];

   logic [TROW_W-1:0] tag_rdata_ff;
   logic [META_W-1:0] meta_rdata_ff;

   // ------------------------------------------------------------------
   // Control and item registers
   // ------------------------------------------------------------------
   sacht_pkg::state_type state_ff, state_in;

   logic [sacht_pkg::SET_BITS-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [sacht_pkg::POLICY_BITS-1:0] policy_ff;
   logic [sacht_pkg::SET_BITS-1:0]    set_ff;
   logic [sacht_pkg::TAG_BITS-1:0]    tag_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff;
   logic [sacht_pkg::SET_BITS-1:0]   rsp_set_ff;
   logic [WAY_W-1:0]                 rsp_way_ff;
   logic [sacht_pkg::COUNT_BITS-1:0] hit_total_ff, hit_total_in;
   logic [sacht_pkg::COUNT_BITS-1:0] access_total_ff, access_total_in;

   logic                           req_take;
   logic                           out_load;
   logic [sacht_pkg::SET_BITS-1:0] req_set;
   logic [sacht_pkg::TAG_BITS-1:0] req_tag;

   // Lookup datapath
   logic                  valid_rd [WAYS];
   logic [RANK_W-1:0]     rank_rd  [WAYS];
   logic [WAYS-1:0]       hit_vec;
   logic                  hit;
   logic [WAY_W-1:0]      way_sel;
   logic                  tag_we;
   logic [TROW_W-1:0]     tag_wdata;
   logic [META_W-1:0]     meta_wdata;
   logic                  meta_we;
   logic [sacht_pkg::SET_BITS-1:0] meta_waddr;

   // Cut the word address into block offset, set and tag
   assign req_set  = req_bus.address[sacht_pkg::OFFSET_BITS +: sacht_pkg::SET_BITS];
   assign req_tag  = req_bus.address[sacht_pkg::ADDR_BITS-1 -: sacht_pkg::TAG_BITS];

   assign req_bus.ready = (state_ff == sacht_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Finish the lookup only when the output register is free or being drained
   assign out_load = (state_ff == sacht_pkg::ST_LOOKUP) && (!rsp_valid_ff || rsp_bus.ready);

   // ------------------------------------------------------------------
   // Lookup: compare tags, pick the way, age the set
   // ------------------------------------------------------------------
   always_comb begin
      logic              hit_found;
      logic [WAY_W-1:0]  hit_way;
      logic              free_found;
      logic [WAY_W-1:0]  free_way;
      logic              vic_found;
      logic [WAY_W-1:0]  vic_way;
      logic [RANK_W-1:0] vic_rank;
      logic              do_touch;
      logic              was_valid;
      logic [RANK_W-1:0] old_rank;
      logic              sel;

      hit_found  = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      vic_found  = 1'b0;
      vic_way    = '0;
      vic_rank   = (policy_ff == sacht_pkg::POL_MRU) ? '0 : OLDEST;

      for (int i = 0; i < WAYS; i++) begin
         valid_rd[i] = meta_rdata_ff[i];
         rank_rd[i]  = meta_rdata_ff[WAYS + i*RANK_W +: RANK_W];
         hit_vec[i]  = valid_rd[i] &&
                       (tag_rdata_ff[i*sacht_pkg::TAG_BITS +: sacht_pkg::TAG_BITS] == tag_ff);
      end

      // Lowest way wins in every search
      for (int i = 0; i < WAYS; i++) begin
         if (!hit_found && hit_vec[i]) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(i);
         end
         if (!free_found && !valid_rd[i]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(i);
         end
         // With every way valid the ranks are a permutation, so the victim
         // is the one holding the newest or the oldest rank
         if (!vic_found && rank_rd[i] == vic_rank) begin
            vic_found = 1'b1;
            vic_way   = WAY_W'(i);
         end
      end

      hit = hit_found;
      priority if (hit_found)  way_sel = hit_way;
      else if (free_found)     way_sel = free_way;
      else                     way_sel = vic_way;

      // FIFO keeps the fill order on a hit
      do_touch  = !(hit_found && policy_ff == sacht_pkg::POL_FIFO);
      was_valid = valid_rd[way_sel];
      old_rank  = rank_rd[way_sel];

      meta_wdata = meta_rdata_ff;
      for (int i = 0; i < WAYS; i++) begin
         sel = (WAY_W'(i) == way_sel);
         if (do_touch) begin
            if (sel) begin
               meta_wdata[WAYS + i*RANK_W +: RANK_W] = '0;
            end else if (valid_rd[i] && (!was_valid || rank_rd[i] < old_rank)) begin
               meta_wdata[WAYS + i*RANK_W +: RANK_W] = rank_rd[i] + 1'b1;
            end
         end
         if (sel) begin
            meta_wdata[i] = 1'b1;
         end
      end

      tag_we    = out_load && !hit_found;
      tag_wdata = tag_rdata_ff;
      tag_wdata[way_sel*sacht_pkg::TAG_BITS +: sacht_pkg::TAG_BITS] = tag_ff;
   end

   // ------------------------------------------------------------------
   // Sequencer: clearing sweep, idle, lookup
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      meta_we    = 1'b0;
      meta_waddr = set_ff;
      unique case (state_ff)
         sacht_pkg::ST_CLEAR: begin
            // Invalidate one set a cycle; ranks go back to zero too
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == sacht_pkg::SET_BITS'(sacht_pkg::SETS - 1)) begin
               state_in = sacht_pkg::ST_IDLE;
            end
         end
         sacht_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = sacht_pkg::ST_LOOKUP;
            end
         end
         sacht_pkg::ST_LOOKUP: begin
            // Hold here, read data intact, until the result can be parked
            if (out_load) begin
               meta_we  = 1'b1;
               state_in = sacht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacht_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sacht_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Memories: one write and one registered read per cycle each
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= (state_ff == sacht_pkg::ST_CLEAR) ? '0 : meta_wdata;
      end
      if (req_take) begin
         meta_rdata_ff <= meta_mem[req_set];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[set_ff] <= tag_wdata;
      end
      if (req_take) begin
         tag_rdata_ff <= tag_mem[req_set];
      end
   end

   // Hold the item's set and tag through the lookup
   always_ff @(posedge clock) begin
      if (req_take) begin
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
   end

   // Policy register
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= sacht_pkg::POL_LRU;
      end else if (csr_bus.valid && csr_bus.ready) begin
         policy_ff <= csr_bus.policy;
      end
   end

   // ------------------------------------------------------------------
   // Counters and output register
   // ------------------------------------------------------------------
   always_comb begin
      hit_total_in    = hit_total_ff;
      access_total_in = access_total_ff;
      if (out_load) begin
         if (hit && hit_total_ff != '1) begin
            hit_total_in = hit_total_ff + 1'b1;
         end
         if (access_total_ff != '1) begin
            access_total_in = access_total_ff + 1'b1;
         end
      end
      priority if (out_load)     rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)    rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         hit_total_ff    <= '0;
         access_total_ff <= '0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         hit_total_ff    <= hit_total_in;
         access_total_ff <= access_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_hit_ff <= hit;
         rsp_set_ff <= set_ff;
         rsp_way_ff <= way_sel;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.set_index    = sacht_pkg::SET_OUT_BITS'(rsp_set_ff);
   assign rsp_bus.way_used     = sacht_pkg::WAY_OUT_BITS'(rsp_way_ff);
   assign rsp_bus.hit_total    = hit_total_ff;
   assign rsp_bus.access_total = access_total_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // A new result appears only out of a lookup
   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(state_ff == sacht_pkg::ST_LOOKUP))
      else $error("result raised without a lookup");

   // A block sits in at most one way of its set
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sacht_pkg::ST_LOOKUP) |-> $onehot0(hit_vec))
      else $error("tag matched in more than one way");

   // Hits never outnumber accesses
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.hit_total <= rsp_bus.access_total))
      else $error("hit count above access count");

   // No item is taken during the clearing sweep
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sacht_pkg::ST_CLEAR) |-> !req_bus.ready)
      else $error("item accepted during clearing sweep");

endmodule
